[hw/rtl/fbsh_pkg.sv]
// Shared types, constants and the character-to-digit map for the
// base-36 folding string hash. No dependencies.
package fbsh_pkg;

  localparam int unsigned HASH_W   = 32;
  localparam int unsigned MOD_W    = 31;
  localparam int unsigned LEN_W    = 8;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned STEP_W   = $clog2(HASH_W);

  localparam logic [HASH_W-1:0] BASE_RADIX      = 32'd36;
  localparam logic [CHAR_W-1:0] DIGIT_ZERO_CODE = 8'd48;
  localparam logic [CHAR_W-1:0] LETTER_OFFSET   = 8'd87;
  localparam logic [CHAR_W-1:0] UPPER_OFFSET    = 8'd55;

  localparam logic [LEN_W-1:0] CHUNK_LENGTH_RESET = 8'd1;
  localparam logic [MOD_W-1:0] MODULUS_RESET      = 31'd1;

  typedef enum logic {
    REG_CHUNK_LENGTH = 1'b0,
    REG_MODULUS      = 1'b1
  } fbsh_reg_t;

  typedef enum logic [2:0] {
    DIV_IDLE = 3'b001,
    DIV_RUN  = 3'b010,
    DIV_DONE = 3'b100
  } fbsh_div_state_t;

  // Finished key handed from the accumulator to the divider.
  typedef struct packed {
    logic              start;
    logic [HASH_W-1:0] sum;
  } fbsh_job_t;

  typedef struct packed {
    logic [LEN_W-1:0] chunk_length;
    logic [MOD_W-1:0] modulus;
  } fbsh_cfg_t;

  function automatic logic [DIGIT_W-1:0] digit_of(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] d;
    d = '0;
    if (code >= DIGIT_ZERO_CODE && code <= DIGIT_ZERO_CODE + 8'd9) begin
      d = code - DIGIT_ZERO_CODE;
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      d = code - UPPER_OFFSET;
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      d = code - LETTER_OFFSET;
    end
    return d[DIGIT_W-1:0];
  endfunction

endpackage

[hw/rtl/fbsh_stream_if.sv]
// Valid/ready stream interfaces for key characters and hash results.
// Depends on fbsh_pkg.
interface fbsh_key_if;
  logic                           valid;
  logic                           ready;
  logic [fbsh_pkg::CHAR_W-1:0]    char_code;
  logic                           last;

  modport source(output valid, output char_code, output last, input ready);
  modport sink(input valid, input char_code, input last, output ready);
endinterface

interface fbsh_hash_if;
  logic                           valid;
  logic                           ready;
  logic signed [fbsh_pkg::HASH_W-1:0] hash_value;

  modport source(output valid, output hash_value, input ready);
  modport sink(input valid, input hash_value, output ready);
endinterface

[hw/rtl/fbsh_cfg.sv]
// APB-style register file: chunk_length and modulus.
// Depends on fbsh_pkg.
module fbsh_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbsh_pkg::APB_AW-1:0]   paddr,
  input  logic [fbsh_pkg::APB_DW-1:0]   pwdata,
  output logic [fbsh_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output fbsh_pkg::fbsh_cfg_t           cfg
);
  import fbsh_pkg::*;

  logic      wr_en;
  fbsh_reg_t reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = fbsh_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_length <= CHUNK_LENGTH_RESET;
      cfg.modulus      <= MODULUS_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_CHUNK_LENGTH: cfg.chunk_length <= pwdata[LEN_W-1:0];
        REG_MODULUS:      cfg.modulus      <= pwdata[MOD_W-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_CHUNK_LENGTH: prdata = {{(APB_DW-LEN_W){1'b0}}, cfg.chunk_length};
      REG_MODULUS:      prdata = {{(APB_DW-MOD_W){1'b0}}, cfg.modulus};
      default:          prdata = '0;
    endcase
  end

endmodule

[hw/rtl/fbsh_fold.sv]
// Horner accumulator: one character per beat into the open chunk,
// chunks folded into the running sum. Depends on fbsh_pkg.
module fbsh_fold (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          take,
  input  logic [fbsh_pkg::CHAR_W-1:0]   char_code,
  input  logic                          last,
  input  logic [fbsh_pkg::LEN_W-1:0]    chunk_length,
  output fbsh_pkg::fbsh_job_t           job
);
  import fbsh_pkg::*;

  logic [HASH_W-1:0] chunk_value, chunk_value_next;
  logic [LEN_W-1:0]  chunk_position, chunk_position_next;
  logic [HASH_W-1:0] running_sum, running_sum_next;
  logic [HASH_W-1:0] horner;
  logic [LEN_W-1:0]  pos_inc;
  logic              close;

  // x*36 as (x<<5)+(x<<2)
  assign horner  = (chunk_value << 5) + (chunk_value << 2)
                 + {{(HASH_W-DIGIT_W){1'b0}}, digit_of(char_code)};
  assign pos_inc = chunk_position + LEN_W'(1);
  assign close   = (pos_inc == chunk_length) | last;

  assign job.start = take & last;
  assign job.sum   = running_sum + horner;

  always_comb begin
    chunk_value_next    = chunk_value;
    chunk_position_next = chunk_position;
    running_sum_next    = running_sum;
    if (take) begin
      if (last) begin
        chunk_value_next    = '0;
        chunk_position_next = '0;
        running_sum_next    = '0;
      end else if (close) begin
        chunk_value_next    = '0;
        chunk_position_next = '0;
        running_sum_next    = running_sum + horner;
      end else begin
        chunk_value_next    = horner;
        chunk_position_next = pos_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_value    <= '0;
      chunk_position <= '0;
      running_sum    <= '0;
    end else begin
      chunk_value    <= chunk_value_next;
      chunk_position <= chunk_position_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

[hw/rtl/fbsh_div.sv]
// Radix-2 restoring remainder unit with sign fix-up and result register.
// One shared subtract/compare per cycle. Depends on fbsh_pkg, fbsh_stream_if.
module fbsh_div (
  input  logic                         clk,
  input  logic                         rst,
  input  fbsh_pkg::fbsh_job_t          job,
  input  logic [fbsh_pkg::MOD_W-1:0]   modulus,
  output logic                         idle,
  fbsh_hash_if.source                  hash_out
);
  import fbsh_pkg::*;

  fbsh_div_state_t   state, state_next;
  logic [HASH_W-1:0] dividend;
  logic [HASH_W-1:0] rem;
  logic [MOD_W-1:0]  divisor;
  logic              neg;
  logic [STEP_W-1:0] step;
  logic [HASH_W-1:0] trial;
  logic [HASH_W:0]   diff;
  logic [HASH_W-1:0] result;
  logic              out_valid;
  logic [HASH_W-1:0] out_data;
  logic              out_free;

  assign trial    = {rem[HASH_W-2:0], dividend[HASH_W-1]};
  assign diff     = {1'b0, trial} - {{(HASH_W+1-MOD_W){1'b0}}, divisor};
  assign result   = (divisor == '0) ? '0 : (neg ? (HASH_W'(0) - rem) : rem);
  assign out_free = ~out_valid | hash_out.ready;
  assign idle     = (state == DIV_IDLE);

  assign hash_out.valid      = out_valid;
  assign hash_out.hash_value = out_data;

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_IDLE: if (job.start) state_next = DIV_RUN;
      DIV_RUN:  if (step == STEP_W'(HASH_W - 1)) state_next = DIV_DONE;
      DIV_DONE: if (out_free) state_next = DIV_IDLE;
      default:  state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= DIV_IDLE;
      out_valid <= 1'b0;
      step      <= '0;
    end else begin
      state <= state_next;
      if (state == DIV_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (hash_out.ready) begin
        out_valid <= 1'b0;
      end
      if (state == DIV_RUN) begin
        step <= step + STEP_W'(1);
      end else begin
        step <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      DIV_IDLE: begin
        if (job.start) begin
          neg      <= job.sum[HASH_W-1];
          dividend <= job.sum[HASH_W-1] ? (HASH_W'(0) - job.sum) : job.sum;
          divisor  <= modulus;
          rem      <= '0;
        end
      end
      DIV_RUN: begin
        dividend <= dividend << 1;
        rem      <= diff[HASH_W] ? trial : diff[HASH_W-1:0];
      end
      DIV_DONE: begin
        if (out_free) begin
          out_data <= result;
        end
      end
      default: ;
    endcase
  end

endmodule

[hw/rtl/fold_base36_string_hash.sv]
// Top level of the base-36 folding string hash.
// Depends on fbsh_pkg, fbsh_stream_if, fbsh_cfg, fbsh_fold, fbsh_div.
//
//   port      dir   beat contents
//   key_in    sink  char_code[7:0], last
//   hash_out  src   hash_value[31:0] signed, one beat per key
//   APB       sink  reg 0x0 chunk_length[7:0], reg 0x4 modulus[30:0]
//
// Non-last characters are taken one per cycle while the divider is idle. A
// last character starts a 32-step remainder in the shared subtractor; the
// result lands in the output register; key_in is not ready until it does.
// A waiting result holds its register; the divider waits behind it.
// Reset is synchronous; it clears all but divider data and readies key_in.
module fold_base36_string_hash (
  input  logic                          clk,
  input  logic                          rst,
  fbsh_key_if.sink                      key_in,
  fbsh_hash_if.source                   hash_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fbsh_pkg::APB_AW-1:0]   paddr,
  input  logic [fbsh_pkg::APB_DW-1:0]   pwdata,
  output logic [fbsh_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import fbsh_pkg::*;

  fbsh_cfg_t cfg;
  fbsh_job_t job;
  logic      div_idle;
  logic      take;

  assign key_in.ready = div_idle;
  assign take         = key_in.valid & div_idle;

  fbsh_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fbsh_fold u_fold (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .char_code    (key_in.char_code),
    .last         (key_in.last),
    .chunk_length (cfg.chunk_length),
    .job          (job)
  );

  fbsh_div u_div (
    .clk      (clk),
    .rst      (rst),
    .job      (job),
    .modulus  (cfg.modulus),
    .idle     (div_idle),
    .hash_out (hash_out)
  );

endmodule

[test/fold_base36_string_hash_test.sv]
// Self-checking testbench for fold_base36_string_hash: key characters in,
// folded base-36 hash out, checked against an in-bench fold predictor or a typed value.
// Depends on fbsh_pkg, fbsh_stream_if and the RTL top level.
module fold_base36_string_hash_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fbsh_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic {
    ROW_CHAR,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    fbsh_reg_t         reg_sel;
    logic [31:0]       value;
    logic              last;
    logic              typed;
    logic [HASH_W-1:0] hash;
  } stim_row_t;

  localparam int unsigned NUM_ROWS = 25;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b1, 1'b1, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, 32'h00,       1'b1, 1'b1, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, 32'hFF,       1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "A",          1'b1, 1'b1, 32'd0},
    '{ROW_CFG,  REG_MODULUS,      32'h7FFFFFFF, 1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b1, 1'b1, 32'd35},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "9",          1'b1, 1'b1, 32'd9},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "Z",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "Z",          1'b1, 1'b1, 32'd70},
    '{ROW_CFG,  REG_CHUNK_LENGTH, 32'd255,      1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "z",          1'b1, 1'b0, 32'd0},
    '{ROW_CFG,  REG_CHUNK_LENGTH, 32'd2,        1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "a",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "b",          1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, "c",          1'b1, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, 32'h2F,       1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, 32'h3A,       1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, 32'h40,       1'b0, 1'b0, 32'd0},
    '{ROW_CHAR, REG_CHUNK_LENGTH, 32'h7B,       1'b1, 1'b1, 32'd0}
  };

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  fbsh_key_if  key_bus ();
  fbsh_hash_if hash_bus ();

  fold_base36_string_hash u_dut (
    .clk      (clk),
    .rst      (rst),
    .key_in   (key_bus),
    .hash_out (hash_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // fold predictor state
  logic [LEN_W-1:0]  cfg_chunk_len;
  logic [MOD_W-1:0]  cfg_modulus;
  logic [HASH_W-1:0] open_chunk;
  logic [LEN_W-1:0]  chunk_fill;
  logic [HASH_W-1:0] closed_sum;

  logic [HASH_W-1:0] hash_expect [$];
  logic [HASH_W-1:0] front_hash;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned chars_sent;
  int unsigned keys_sent;
  int unsigned hashes_seen;
  int unsigned cfg_writes;

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d hashes pending", cycle_count, hash_expect.size());
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic [HASH_W-1:0] base36_digit(input logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] lc;
    lc = (code >= 8'h41 && code <= 8'h5A) ? (code | 8'h20) : code;
    if (lc >= DIGIT_ZERO_CODE && lc <= DIGIT_ZERO_CODE + 8'd9) begin
      return HASH_W'(lc - DIGIT_ZERO_CODE);
    end
    if (lc >= 8'h61 && lc <= 8'h7A) begin
      return HASH_W'(lc - LETTER_OFFSET);
    end
    return '0;
  endfunction

  // remainder of a signed 32-bit sum, truncated toward zero
  function automatic logic [HASH_W-1:0] trunc_rem(input logic [HASH_W-1:0] sum,
                                                   input logic [MOD_W-1:0] m);
    logic [HASH_W-1:0] mag;
    logic [HASH_W-1:0] r;
    if (m == '0) begin
      return '0;
    end
    mag = sum[HASH_W-1] ? -sum : sum;
    r = mag % {1'b0, m};
    return sum[HASH_W-1] ? -r : r;
  endfunction

  function automatic logic fold_char(input logic [CHAR_W-1:0] code, input logic last,
                                     output logic [HASH_W-1:0] hash);
    open_chunk = open_chunk * BASE_RADIX + base36_digit(code);
    chunk_fill = chunk_fill + 8'd1;
    if (chunk_fill == cfg_chunk_len || last) begin
      closed_sum = closed_sum + open_chunk;
      open_chunk = '0;
      chunk_fill = '0;
    end
    hash = trunc_rem(closed_sum, cfg_modulus);
    if (last) begin
      closed_sum = '0;
    end
    return last;
  endfunction

  task automatic note_mismatch(input string what, input logic [HASH_W-1:0] exp_v,
                               input logic [HASH_W-1:0] act_v);
    error_count++;
    if (error_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected %0d (0x%08h), got %0d (0x%08h)", what,
               $signed(exp_v), exp_v, $signed(act_v), act_v);
    end
  endtask

  always @(negedge clk) begin
    hash_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && hash_bus.valid && hash_bus.ready) begin
      if (hash_expect.size() == 0) begin
        note_mismatch("hash beat with none pending", '0, hash_bus.hash_value);
      end else begin
        front_hash = hash_expect.pop_front();
        hashes_seen++;
        if (hash_bus.hash_value !== front_hash) begin
          note_mismatch("hash_value", front_hash, hash_bus.hash_value);
        end
      end
    end
  end

  task automatic send_char(input logic [CHAR_W-1:0] code, input logic last,
                           input logic typed, input logic [HASH_W-1:0] typed_hash);
    logic [HASH_W-1:0] hash;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      key_bus.valid <= 1'b0;
      @(negedge clk);
    end
    key_bus.valid     <= 1'b1;
    key_bus.char_code <= code;
    key_bus.last      <= last;
    do @(posedge clk); while (!key_bus.ready);
    chars_sent++;
    if (fold_char(code, last, hash)) begin
      keys_sent++;
      hash_expect.push_back(typed ? typed_hash : hash);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    key_bus.valid <= 1'b0;
    while (hash_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register
  task automatic reg_write(input fbsh_reg_t sel, input logic [31:0] data);
    logic [APB_DW-1:0] rd;
    logic [APB_DW-1:0] want;
    want = (sel == REG_CHUNK_LENGTH) ? {24'd0, data[LEN_W-1:0]} : {1'b0, data[MOD_W-1:0]};
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (sel == REG_CHUNK_LENGTH) begin
      cfg_chunk_len = data[LEN_W-1:0];
    end else begin
      cfg_modulus = data[MOD_W-1:0];
    end
    cfg_writes++;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd !== want) begin
      note_mismatch("register read-back", want, rd);
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] random_char();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 3) return CHAR_W'($urandom_range(8'h7A, 8'h61));
    if (pick < 5) return CHAR_W'($urandom_range(8'h5A, 8'h41));
    if (pick < 7) return CHAR_W'($urandom_range(8'h39, 8'h30));
    return CHAR_W'($urandom_range(255));
  endfunction

  task automatic send_key(output int unsigned len);
    len = ($urandom_range(9) == 0) ? $urandom_range(300, 20) : $urandom_range(12, 1);
    for (int unsigned i = 0; i < len; i++) begin
      send_char(random_char(), i == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    int unsigned seg_items;
    int unsigned key_len;
    logic [31:0] len_v;
    logic [31:0] mod_v;

    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    key_bus.valid = 1'b0;
    key_bus.char_code = '0;
    key_bus.last = 1'b0;
    hash_bus.ready = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    cycle_count = 0;
    error_count = 0;
    chars_sent = 0;
    keys_sent = 0;
    hashes_seen = 0;
    cfg_writes = 0;
    cfg_chunk_len = CHUNK_LENGTH_RESET;
    cfg_modulus = MODULUS_RESET;
    open_chunk = '0;
    chunk_fill = '0;
    closed_sum = '0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int unsigned i = 0; i < NUM_ROWS; i++) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain();
        reg_write(directed_rows[i].reg_sel, directed_rows[i].value);
      end else begin
        send_char(directed_rows[i].value[CHAR_W-1:0], directed_rows[i].last,
                  directed_rows[i].typed, directed_rows[i].hash);
      end
    end
    drain();

    for (int unsigned phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 18;
          recv_idle_pct = 61;
        end
        1: begin
          send_idle_pct = 61;
          recv_idle_pct = 18;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int unsigned seg = 0; seg < 5; seg++) begin
        case (seg)
          0: begin
            len_v = 32'd1;
            mod_v = 32'h7FFFFFFF;
          end
          1: begin
            len_v = 32'd255;
            mod_v = 32'd1;
          end
          2: begin
            len_v = $urandom_range(8, 1);
            mod_v = $urandom_range(100, 1);
          end
          3: begin
            len_v = $urandom_range(255, 1);
            mod_v = $urandom_range(32'h7FFFFFFF, 1);
          end
          default: begin
            len_v = $urandom_range(16, 2);
            mod_v = $urandom_range(32'h7FFFFFFF, 1);
          end
        endcase
        reg_write(REG_CHUNK_LENGTH, len_v);
        reg_write(REG_MODULUS, mod_v);
        seg_items = 0;
        while (seg_items < 100) begin
          send_key(key_len);
          seg_items += key_len;
        end
        drain();
      end
    end

    $display("Sent %0d characters in %0d keys over %0d register writes", chars_sent,
             keys_sent, cfg_writes);
    $display("Checked %0d hashes, %0d mismatches", hashes_seen, error_count);
    if (error_count == 0 && hash_expect.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
hw/rtl/fbsh_pkg.sv
hw/rtl/fbsh_stream_if.sv
hw/rtl/fbsh_cfg.sv
hw/rtl/fbsh_fold.sv
hw/rtl/fbsh_div.sv
hw/rtl/fold_base36_string_hash.sv
test/fold_base36_string_hash_test.sv
